[design/alm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alm_pkg
// Shared constants, codes and types of the array list engine.
// ----------------------------------------------------------------------------
package alm_pkg;

    localparam int DEPTH       = 16;
    localparam int MAX_RESULTS = 16;

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int VAL_W  = 32;
    localparam int OP_W   = 3;
    localparam int POS_W  = 4;
    localparam int STAT_W = 3;
    localparam int EIDX_W = 4;
    localparam int ECNT_W = 5;
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Number of entries listed at most in one listing.
    localparam int LIST_MAX = (DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS;

    localparam int S_DATA_W = ((VAL_W + POS_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((STAT_W + EIDX_W + VAL_W + ECNT_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_SORT   = 3'd2,
        OP_LIST   = 3'd3,
        OP_SEARCH = 3'd4
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_EMPTY     = 3'd2,
        STAT_BAD_POS   = 3'd3,
        STAT_NOT_FOUND = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SORT,
        S_LIST,
        S_SEARCH
    } state_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic load;   // cell at the fill count takes the key
        logic shift;  // cells from the position upwards take their right neighbour
        logic sort;   // compare and exchange with the paired neighbour
        logic odd;    // pairing parity of the current sort phase
    } cell_ctrl_t;

endpackage

[design/array_list_engine_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_engine_top
// Ordered list of signed 32-bit values kept in a chain of storage cells.
// ----------------------------------------------------------------------------
// Insert and delete each give one transaction; unused operation codes are
// absorbed without a result. Search: every cell compares its entry with the
// key in parallel, the match vector is registered, and the first match is
// picked from it in the search state. A listing gives one transaction per
// cycle while m_tready does not hold the output register, one per entry (a
// single one for an empty list). Sort runs DEPTH odd-even exchange phases
// through the cell chain, one phase per cycle, before it lists. One operation
// is handled at a time; once the last result of the current one is in the
// output register, the next transaction is taken as soon as that register is
// empty or is being read in the same cycle.
module array_list_engine_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [alm_pkg::S_DATA_W-1:0]   s_tdata,  // item_value, position, pad
    input  logic [alm_pkg::OP_W-1:0]       s_tuser,  // op
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [alm_pkg::M_DATA_W-1:0]   m_tdata,  // status, entry_index,
                                                     // entry_value, count, pad
    output logic                           m_tlast,
    output logic                           m_tuser   // has_value
);
    import alm_pkg::*;

    state_t state_reg, state_next;

    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [IDX_W-1:0] phase_reg, phase_next;
    logic [CNT_W-1:0] list_idx_reg, list_idx_next;
    logic [DEPTH-1:0] match_reg, match_next;

    logic                    m_valid_reg, m_valid_next;
    status_t                 out_status_reg, out_status_next;
    logic [EIDX_W-1:0]       out_index_reg, out_index_next;
    logic signed [VAL_W-1:0] out_value_reg, out_value_next;
    logic                    out_has_reg, out_has_next;
    logic                    out_last_reg, out_last_next;
    logic [ECNT_W-1:0]       out_count_reg, out_count_next;

    cell_ctrl_t              ctrl;
    logic signed [VAL_W-1:0] cell_value [DEPTH];
    logic [DEPTH-1:0]        cell_match;

    logic signed [VAL_W-1:0] key;
    logic [POS_W-1:0]        position;
    op_t                     op;
    logic                    accept_in;
    logic                    out_free;
    logic [CNT_W-1:0]        list_n;
    logic                    list_last;
    logic [IDX_W-1:0]        first_idx;
    logic [IDX_W-1:0]        rd_addr;
    logic signed [VAL_W-1:0] rd_value;

    assign key      = s_tdata[VAL_W-1:0];
    assign position = s_tdata[VAL_W+POS_W-1:VAL_W];
    assign op       = op_t'(s_tuser);

    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && out_free;
    assign accept_in = s_tvalid && s_tready;

    // Cell chain.
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic signed [VAL_W-1:0] left_value;
            logic signed [VAL_W-1:0] right_value;
            if (g == 0) begin : g_first
                assign left_value = '0;
            end else begin : g_inner_l
                assign left_value = cell_value[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign right_value = '0;
            end else begin : g_inner_r
                assign right_value = cell_value[g+1];
            end
            alm_cell u_cell (
                .aclk        (aclk),
                .ctrl        (ctrl),
                .idx         (CNT_W'(g)),
                .count       (fill_reg),
                .pos         (CNT_W'(position)),
                .key         (key),
                .left_value  (left_value),
                .right_value (right_value),
                .value       (cell_value[g]),
                .match       (cell_match[g])
            );
        end
    endgenerate

    // Lowest matching cell wins.
    always_comb begin
        first_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (match_reg[i]) begin
                first_idx = IDX_W'(i);
            end
        end
    end

    assign list_n    = (fill_reg > CNT_W'(LIST_MAX)) ? CNT_W'(LIST_MAX) : fill_reg;
    assign list_last = (fill_reg == '0) || ((list_idx_reg + CNT_W'(1)) == list_n);
    assign rd_addr   = (state_reg == S_SEARCH) ? first_idx : list_idx_reg[IDX_W-1:0];
    assign rd_value  = cell_value[rd_addr];

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept_in) begin
                    unique case (op)
                        OP_SORT:   state_next = S_SORT;
                        OP_LIST:   state_next = S_LIST;
                        OP_SEARCH: state_next = S_SEARCH;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_SORT: begin
                if (phase_reg == IDX_W'(DEPTH - 1)) begin
                    state_next = S_LIST;
                end
            end
            S_LIST: begin
                if (out_free && list_last) begin
                    state_next = S_IDLE;
                end
            end
            S_SEARCH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath control and result formation.
    always_comb begin
        ctrl            = '0;
        fill_next       = fill_reg;
        phase_next      = phase_reg;
        list_idx_next   = list_idx_reg;
        match_next      = match_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        out_value_next  = out_value_reg;
        out_has_next    = out_has_reg;
        out_last_next   = out_last_reg;
        out_count_next  = out_count_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept_in) begin
                    unique case (op)
                        OP_INSERT: begin
                            m_valid_next = 1'b1;
                            if (fill_reg == CNT_W'(DEPTH)) begin
                                out_status_next = STAT_FULL;
                            end else begin
                                ctrl.load       = 1'b1;
                                fill_next       = fill_reg + CNT_W'(1);
                                out_status_next = STAT_OK;
                            end
                        end
                        OP_DELETE: begin
                            m_valid_next = 1'b1;
                            if (fill_reg == '0) begin
                                out_status_next = STAT_EMPTY;
                            end else if (CMP_W'(position) >= CMP_W'(fill_reg)) begin
                                out_status_next = STAT_BAD_POS;
                            end else begin
                                ctrl.shift      = 1'b1;
                                fill_next       = fill_reg - CNT_W'(1);
                                out_status_next = STAT_OK;
                            end
                        end
                        OP_SORT: begin
                            phase_next    = '0;
                            list_idx_next = '0;
                        end
                        OP_LIST: begin
                            list_idx_next = '0;
                        end
                        OP_SEARCH: begin
                            match_next = cell_match;
                        end
                        default: begin
                        end
                    endcase
                    out_index_next = '0;
                    out_value_next = '0;
                    out_has_next   = 1'b0;
                    out_last_next  = 1'b1;
                    out_count_next = ECNT_W'(fill_next);
                end
            end
            S_SORT: begin
                ctrl.sort  = 1'b1;
                ctrl.odd   = phase_reg[0];
                phase_next = phase_reg + IDX_W'(1);
            end
            S_LIST: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    out_status_next = STAT_OK;
                    out_last_next   = list_last;
                    out_count_next  = ECNT_W'(fill_reg);
                    if (fill_reg == '0) begin
                        out_index_next = '0;
                        out_value_next = '0;
                        out_has_next   = 1'b0;
                    end else begin
                        out_index_next = EIDX_W'(list_idx_reg);
                        out_value_next = rd_value;
                        out_has_next   = 1'b1;
                        list_idx_next  = list_idx_reg + CNT_W'(1);
                    end
                end
            end
            S_SEARCH: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    out_last_next  = 1'b1;
                    out_count_next = ECNT_W'(fill_reg);
                    if (match_reg != '0) begin
                        out_status_next = STAT_OK;
                        out_index_next  = EIDX_W'(first_idx);
                        out_value_next  = rd_value;
                        out_has_next    = 1'b1;
                    end else begin
                        out_status_next = STAT_NOT_FOUND;
                        out_index_next  = '0;
                        out_value_next  = '0;
                        out_has_next    = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        phase_reg      <= phase_next;
        list_idx_reg   <= list_idx_next;
        match_reg      <= match_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        out_value_reg  <= out_value_next;
        out_has_reg    <= out_has_next;
        out_last_reg   <= out_last_next;
        out_count_reg  <= out_count_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_has_reg;
    assign m_tdata  = M_DATA_W'({out_count_reg, out_value_reg, out_index_reg,
                                 out_status_reg});

endmodule

[design/alm_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alm_cell
// One storage cell of the list chain with its neighbour exchange logic.
// ----------------------------------------------------------------------------
module alm_cell (
    input  logic                              aclk,
    input  alm_pkg::cell_ctrl_t               ctrl,
    input  logic        [alm_pkg::CNT_W-1:0]  idx,
    input  logic        [alm_pkg::CNT_W-1:0]  count,
    input  logic        [alm_pkg::CNT_W-1:0]  pos,
    input  logic signed [alm_pkg::VAL_W-1:0]  key,
    input  logic signed [alm_pkg::VAL_W-1:0]  left_value,
    input  logic signed [alm_pkg::VAL_W-1:0]  right_value,
    output logic signed [alm_pkg::VAL_W-1:0]  value,
    output logic                              match
);
    import alm_pkg::*;

    logic signed [VAL_W-1:0] value_reg;
    logic signed [VAL_W-1:0] value_next;
    logic                    has_right;
    logic                    is_lower;
    logic                    is_upper;

    assign has_right = (idx + CNT_W'(1)) < count;
    assign is_lower  = (idx[0] == ctrl.odd) && has_right;
    assign is_upper  = (idx[0] != ctrl.odd) && (idx != '0) && (idx < count);

    always_comb begin
        value_next = value_reg;
        if (ctrl.load && (idx == count)) begin
            value_next = key;
        end else if (ctrl.shift && (idx >= pos) && has_right) begin
            value_next = right_value;
        end else if (ctrl.sort) begin
            if (is_lower && (value_reg > right_value)) begin
                value_next = right_value;
            end else if (is_upper && (left_value > value_reg)) begin
                value_next = left_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign match = (value_reg == key) && (idx < count);

endmodule
